// File: rtl/rda_pkg.sv
// Shared types, constants and helpers for the radiation drag accelerator.
// No dependencies; the other rtl files but rda_checker refer to it by scoped names.
package rda_pkg;

  // 1/c in Q60, c being the speed of light in simulation units
  localparam logic [63:0] INV_C_Q60 = 64'd114548520276345;
  localparam logic [63:0] MAG_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] OUT_POS_MAX = 64'h007F_FFFF_FFFF_FFFF;
  localparam logic [63:0] OUT_NEG_MAX = 64'h0080_0000_0000_0000;

  // configuration register indexes
  localparam logic [3:0] REG_STAR_POS_X = 4'd0;
  localparam logic [3:0] REG_STAR_VEL_X = 4'd3;
  localparam logic [3:0] REG_GRAV_CONST = 4'd6;
  localparam logic [3:0] REG_STAR_MASS  = 4'd7;

  localparam int QPTRW = 1;  // queue holds 2 words

  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } arith_op_e;

  typedef struct packed {
    arith_op_e    op;
    logic [127:0] a;
    logic [63:0]  b;
  } arith_req_t;

  typedef logic [56:0] diff_t;

  typedef struct packed {
    logic        skip;
    logic [32:0] beta;
    diff_t [2:0] d;
    diff_t [2:0] dv;
  } item_t;

  typedef struct packed {
    logic [54:0] grav;
    logic [54:0] mass;
  } gm_cfg_t;

  // clamp an unsigned magnitude to 2^63-1, msb of the result flags the clip
  function automatic logic [64:0] clamp63(input logic [127:0] x);
    logic over;
    over = |x[127:63];
    return over ? {1'b1, MAG_MAX} : {1'b0, x[63:0]};
  endfunction

endpackage

// File: rtl/rda_fifo.sv
// Two-word queue between front and back of the radiation drag accelerator.
// Depends on rda_pkg (item_t, QPTRW).
module rda_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rda_pkg::item_t item_i,
  output logic           full_o,
  input  logic           pop_i,
  output rda_pkg::item_t item_o,
  output logic           empty_o
);

  rda_pkg::item_t             mem_q [2];
  logic [rda_pkg::QPTRW-1:0]  wr_q, rd_q;
  logic [rda_pkg::QPTRW:0]    cnt_q;

  assign full_o  = cnt_q[rda_pkg::QPTRW];
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        mem_q[wr_q] <= item_i;
        wr_q        <= wr_q + 1'b1;
      end
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// File: rtl/rda_front.sv
// Front of the radiation drag accelerator: config registers, input
// classification and relative state. Depends on rda_pkg.
module rda_front #(
  parameter int FIRST_DUST_INDEX = 4,
  parameter int FRAC_BITS        = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [55:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        particle_index_i,
  input  logic               is_massless_i,
  input  logic [32:0]        beta_ratio_i,
  input  logic [55:0]        dust_x_i,
  input  logic [55:0]        dust_y_i,
  input  logic [55:0]        dust_z_i,
  input  logic [55:0]        dust_vx_i,
  input  logic [55:0]        dust_vy_i,
  input  logic [55:0]        dust_vz_i,
  input  logic               q_full_i,
  output logic               q_push_o,
  output rda_pkg::item_t     q_item_o,
  output rda_pkg::gm_cfg_t   gm_cfg_o
);

  logic [55:0] star_q [6];
  logic [54:0] grav_q, mass_q;
  logic [55:0] pos [3];
  logic [55:0] vel [3];

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_full_i;
  assign q_push_o    = in_valid_i && !q_full_i;
  assign gm_cfg_o    = '{grav: grav_q, mass: mass_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) star_q[i] <= '0;
      grav_q <= 55'(64'd1 << FRAC_BITS);
      mass_q <= 55'(64'd1 << FRAC_BITS);
    end else if (cfg_valid_i) begin
      if (cfg_index_i < rda_pkg::REG_GRAV_CONST) star_q[cfg_index_i[2:0]] <= cfg_data_i;
      else if (cfg_index_i == rda_pkg::REG_GRAV_CONST) grav_q <= cfg_data_i[54:0];
      else if (cfg_index_i == rda_pkg::REG_STAR_MASS) mass_q <= cfg_data_i[54:0];
    end
  end

  always_comb begin
    pos = '{dust_x_i, dust_y_i, dust_z_i};
    vel = '{dust_vx_i, dust_vy_i, dust_vz_i};
    q_item_o.skip = (particle_index_i < 16'(FIRST_DUST_INDEX)) || !is_massless_i
                    || (beta_ratio_i == '0);
    q_item_o.beta = beta_ratio_i;
    for (int i = 0; i < 3; i++) begin
      q_item_o.d[i]  = {pos[i][55], pos[i]} -
                       {star_q[i][55], star_q[i]};
      q_item_o.dv[i] = {vel[i][55], vel[i]} -
                       {star_q[i+3][55], star_q[i+3]};
    end
  end

endmodule

// File: rtl/rda_arith.sv
// Shared iterative arithmetic unit: 64x64 multiply from one 32x32 product
// per cycle, 128/64 restoring divide and 128-bit square root. Uses rda_pkg.
module rda_arith (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  rda_pkg::arith_req_t req_i,
  output logic                done_o,
  output logic [127:0]        result_o
);

  rda_pkg::arith_op_e op_q;
  logic [127:0] a_q, acc_q;
  logic [63:0]  b_q, root_q;
  logic [65:0]  rem_q;
  logic [6:0]   cnt_q, last;
  logic         busy_q, done_q;

  logic [31:0]  aseg, bseg;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [64:0]  dcat;
  logic         dge;
  logic [67:0]  scat, strial;
  logic         sge;

  always_comb begin
    aseg  = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    bseg  = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp    = aseg * bseg;
    pp_sh = {64'd0, pp} << {(2'(cnt_q[1]) + 2'(cnt_q[0])), 5'd0};
    dcat  = {rem_q[63:0], a_q[127]};
    dge   = dcat >= {1'b0, b_q};
    scat  = {rem_q, a_q[127:126]};
    strial = {2'b00, root_q, 2'b01};
    sge   = scat >= strial;
    case (op_q)
      rda_pkg::OP_MUL:  last = 7'd3;
      rda_pkg::OP_DIV:  last = 7'd127;
      rda_pkg::OP_SQRT: last = 7'd63;
      default:          last = 7'd0;
    endcase
    case (op_q)
      rda_pkg::OP_MUL:  result_o = acc_q;
      rda_pkg::OP_DIV:  result_o = a_q;
      rda_pkg::OP_SQRT: result_o = {64'd0, root_q};
      default:          result_o = '0;
    endcase
  end

  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= rda_pkg::OP_MUL;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        op_q   <= req_i.op;
        a_q    <= req_i.a;
        b_q    <= req_i.b;
        acc_q  <= '0;
        rem_q  <= '0;
        root_q <= '0;
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        case (op_q)
          rda_pkg::OP_MUL: acc_q <= acc_q + pp_sh;
          rda_pkg::OP_DIV: begin
            rem_q <= {2'b00, dge ? 64'(dcat - {1'b0, b_q}) : dcat[63:0]};
            a_q   <= {a_q[126:0], dge};
          end
          rda_pkg::OP_SQRT: begin
            rem_q  <= sge ? 66'(scat - strial) : scat[65:0];
            root_q <= {root_q[62:0], sge};
            a_q    <= {a_q[125:0], 2'b00};
          end
          default: ;
        endcase
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/rda_back.sv
// Back of the radiation drag accelerator: sequences one particle through
// the shared arithmetic unit and holds the output register. Uses rda_pkg.
module rda_back #(
  parameter int FRAC_BITS = 40
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_empty_i,
  input  rda_pkg::item_t     q_item_i,
  output logic               q_pop_o,
  input  rda_pkg::gm_cfg_t   gm_cfg_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [55:0]        accel_x_o,
  output logic [55:0]        accel_y_o,
  output logic [55:0]        accel_z_o,
  output logic               applied_o,
  output logic               saturated_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_R2, S_DOT, S_SQRT, S_DDIV, S_QMUL, S_GM, S_K,
    S_T, S_FR, S_U, S_P1, S_P2, S_ACC, S_OUT
  } st_e;

  st_e            state_q;
  logic           issued_q;
  logic [1:0]     idx_q;
  rda_pkg::item_t item_q;
  logic [127:0]   r2_q, dpos_q, dneg_q;
  logic [63:0]    r_q, rdm_q, qm_q, gm_q, k_q, t_q, fr_q, um_q, p1_q, p2_q;
  logic           rdneg_q, qneg_q, uneg_q, sat_q, applied_q;
  logic [55:0]    accel_q [3];
  logic           out_valid_q;

  rda_pkg::arith_req_t req;
  logic          start, done;
  logic [127:0]  res;
  logic          d_neg, dv_neg, dot_neg, acc_neg, osat, issue;
  logic [56:0]   dm, dvm;
  logic [127:0]  dot;
  logic [64:0]  c0, c32, cfb, c60;
  logic [63:0]  u_val, term, term_mag, acc_m, acc_w;

  rda_arith u_arith (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .req_i    (req),
    .done_o   (done),
    .result_o (res)
  );

  always_comb begin
    d_neg   = item_q.d[idx_q][56];
    dv_neg  = item_q.dv[idx_q][56];
    dm      = d_neg ? 57'd0 - item_q.d[idx_q] : item_q.d[idx_q];
    dvm     = dv_neg ? 57'd0 - item_q.dv[idx_q] : item_q.dv[idx_q];
    dot_neg = dneg_q > dpos_q;
    dot     = dot_neg ? dneg_q - dpos_q : dpos_q - dneg_q;
    c0      = rda_pkg::clamp63(res);
    c32     = rda_pkg::clamp63(res >> 32);
    cfb     = rda_pkg::clamp63(res >> FRAC_BITS);
    c60     = rda_pkg::clamp63(res >> 60);
    u_val   = uneg_q ? 64'd0 - um_q : um_q;
    term    = u_val - p1_q - p2_q;
    term_mag = term[63] ? 64'd0 - term : term;
    acc_m   = cfb[63:0];
    acc_neg = term[63] && (acc_m != '0);
    osat    = 1'b0;
    if (acc_neg) begin
      if (acc_m > rda_pkg::OUT_NEG_MAX) begin
        acc_w = 64'd0 - rda_pkg::OUT_NEG_MAX;
        osat  = 1'b1;
      end else begin
        acc_w = 64'd0 - acc_m;
      end
    end else begin
      if (acc_m > rda_pkg::OUT_POS_MAX) begin
        acc_w = rda_pkg::OUT_POS_MAX;
        osat  = 1'b1;
      end else begin
        acc_w = acc_m;
      end
    end

    issue = 1'b1;
    req   = '{op: rda_pkg::OP_MUL, a: '0, b: '0};
    case (state_q)
      S_R2:   req = '{op: rda_pkg::OP_MUL, a: 128'(dm), b: 64'(dm)};
      S_DOT:  req = '{op: rda_pkg::OP_MUL, a: 128'(dm), b: 64'(dvm)};
      S_SQRT: req = '{op: rda_pkg::OP_SQRT, a: r2_q, b: '0};
      S_DDIV: req = '{op: rda_pkg::OP_DIV, a: dot, b: r_q};
      S_QMUL: req = '{op: rda_pkg::OP_MUL, a: 128'(rdm_q), b: rda_pkg::INV_C_Q60};
      S_GM:   req = '{op: rda_pkg::OP_MUL, a: 128'(gm_cfg_i.grav), b: 64'(gm_cfg_i.mass)};
      S_K:    req = '{op: rda_pkg::OP_MUL, a: 128'(gm_q), b: 64'(item_q.beta)};
      S_T:    req = '{op: rda_pkg::OP_DIV, a: {64'd0, k_q} << FRAC_BITS, b: r_q};
      S_FR:   req = '{op: rda_pkg::OP_DIV, a: {64'd0, t_q} << FRAC_BITS, b: r_q};
      S_U:    req = '{op: rda_pkg::OP_DIV, a: {71'd0, dm} << FRAC_BITS, b: r_q};
      S_P1:   req = '{op: rda_pkg::OP_MUL, a: 128'(qm_q), b: um_q};
      S_P2:   req = '{op: rda_pkg::OP_MUL, a: 128'(dvm), b: rda_pkg::INV_C_Q60};
      S_ACC:  req = '{op: rda_pkg::OP_MUL, a: 128'(fr_q), b: term_mag};
      default: issue = 1'b0;
    endcase
    start = issue && !issued_q;
  end

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issued_q    <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      // in S_OUT a taken word is replaced by the next one below
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) out_valid_q <= 1'b0;
      if (start) issued_q <= 1'b1;
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            item_q    <= q_item_i;
            r2_q      <= '0;
            dpos_q    <= '0;
            dneg_q    <= '0;
            sat_q     <= 1'b0;
            applied_q <= !q_item_i.skip;
            idx_q     <= '0;
            for (int i = 0; i < 3; i++) accel_q[i] <= '0;
            state_q   <= q_item_i.skip ? S_OUT : S_R2;
          end
        end
        S_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            accel_x_o   <= accel_q[0];
            accel_y_o   <= accel_q[1];
            accel_z_o   <= accel_q[2];
            applied_o   <= applied_q;
            saturated_o <= sat_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          if (issued_q && done) begin
            issued_q <= 1'b0;
            case (state_q)
              S_R2: begin
                r2_q <= r2_q + res;
                idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 1'b1;
                if (idx_q == 2'd2) state_q <= S_DOT;
              end
              S_DOT: begin
                if (d_neg != dv_neg) dneg_q <= dneg_q + res;
                else dpos_q <= dpos_q + res;
                idx_q <= (idx_q == 2'd2) ? 2'd0 : idx_q + 1'b1;
                if (idx_q == 2'd2) state_q <= S_SQRT;
              end
              S_SQRT: begin
                r_q <= res[63:0];
                if (res[63:0] == '0) begin
                  sat_q   <= 1'b1;
                  state_q <= S_OUT;
                end else begin
                  state_q <= S_DDIV;
                end
              end
              S_DDIV: begin
                rdm_q   <= c0[63:0];
                sat_q   <= sat_q | c0[64];
                rdneg_q <= dot_neg;
                state_q <= S_QMUL;
              end
              S_QMUL: begin
                qm_q    <= c60[63:0];
                qneg_q  <= rdneg_q && (rdm_q != '0);
                sat_q   <= sat_q | c60[64];
                state_q <= S_GM;
              end
              S_GM: begin
                gm_q    <= cfb[63:0];
                sat_q   <= sat_q | cfb[64];
                state_q <= S_K;
              end
              S_K: begin
                k_q     <= c32[63:0];
                sat_q   <= sat_q | c32[64];
                state_q <= S_T;
              end
              S_T: begin
                t_q     <= c0[63:0];
                sat_q   <= sat_q | c0[64];
                state_q <= S_FR;
              end
              S_FR: begin
                fr_q    <= c0[63:0];
                sat_q   <= sat_q | c0[64];
                idx_q   <= '0;
                state_q <= S_U;
              end
              S_U: begin
                um_q    <= c0[63:0];
                uneg_q  <= d_neg && (c0[63:0] != '0);
                sat_q   <= sat_q | c0[64];
                state_q <= S_P1;
              end
              S_P1: begin
                p1_q    <= (qneg_q != uneg_q) ? 64'd0 - cfb[63:0] : cfb[63:0];
                sat_q   <= sat_q | cfb[64];
                state_q <= S_P2;
              end
              S_P2: begin
                p2_q    <= dv_neg ? 64'd0 - c60[63:0] : c60[63:0];
                sat_q   <= sat_q | c60[64];
                state_q <= S_ACC;
              end
              S_ACC: begin
                accel_q[idx_q] <= acc_w[55:0];
                sat_q <= sat_q | cfb[64] | osat;
                if (idx_q == 2'd2) begin
                  state_q <= S_OUT;
                end else begin
                  idx_q   <= idx_q + 1'b1;
                  state_q <= S_U;
                end
              end
              default: state_q <= S_IDLE;
            endcase
          end
        end
      endcase
    end
  end

endmodule

// File: rtl/radiation_drag_accel_top.sv
// Top level of the radiation pressure / drag accelerator.
// Depends on rda_pkg, rda_front, rda_fifo, rda_back (and rda_arith below it).
//
//   channel | direction | handshake                 | word
//   --------+-----------+---------------------------+----------------------------
//   cfg     | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//   in      | in        | in_valid_i / in_ready_o   | particle fields
//   out     | out       | out_valid_o / out_ready_i | accel_x/y/z, applied, saturated
//
// Sequencing: a skipped particle goes straight to the output register. A
// dust particle runs through the shared bit-serial unit in turn: six
// divides, a square root and eighteen multiplies, each issued to the unit
// and handed back; a zero radius ends it after the square root.
// Reset: rst_ni clears control state at once; config regs return to star at
// the origin at rest and G = M = 1.0. Stalls: a two-word queue lets the
// front keep taking words, until it is full, while the back works or waits on out_ready_i.
module radiation_drag_accel_top #(
  parameter int FIRST_DUST_INDEX = 4,
  parameter int FRAC_BITS        = 40
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [55:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] particle_index_i,
  input  logic        is_massless_i,
  input  logic [32:0] beta_ratio_i,
  input  logic [55:0] dust_x_i,
  input  logic [55:0] dust_y_i,
  input  logic [55:0] dust_z_i,
  input  logic [55:0] dust_vx_i,
  input  logic [55:0] dust_vy_i,
  input  logic [55:0] dust_vz_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [55:0] accel_x_o,
  output logic [55:0] accel_y_o,
  output logic [55:0] accel_z_o,
  output logic        applied_o,
  output logic        saturated_o
);

  rda_pkg::item_t   push_item, pop_item;
  rda_pkg::gm_cfg_t gm_cfg;
  logic             push, pop, full, empty;

  // front: config regs, skip classification, star-relative state
  rda_front #(
    .FIRST_DUST_INDEX (FIRST_DUST_INDEX),
    .FRAC_BITS        (FRAC_BITS)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .particle_index_i (particle_index_i),
    .is_massless_i    (is_massless_i),
    .beta_ratio_i     (beta_ratio_i),
    .dust_x_i         (dust_x_i),
    .dust_y_i         (dust_y_i),
    .dust_z_i         (dust_z_i),
    .dust_vx_i        (dust_vx_i),
    .dust_vy_i        (dust_vy_i),
    .dust_vz_i        (dust_vz_i),
    .q_full_i         (full),
    .q_push_o         (push),
    .q_item_o         (push_item),
    .gm_cfg_o         (gm_cfg)
  );

  // decoupling queue
  rda_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (pop_item),
    .empty_o (empty)
  );

  // back: sequenced force evaluation and the output register
  rda_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (empty),
    .q_item_i    (pop_item),
    .q_pop_o     (pop),
    .gm_cfg_i    (gm_cfg),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .accel_x_o   (accel_x_o),
    .accel_y_o   (accel_y_o),
    .accel_z_o   (accel_z_o),
    .applied_o   (applied_o),
    .saturated_o (saturated_o)
  );

endmodule

// File: rtl/rda_checker.sv
// Port-level assertions for radiation_drag_accel_top, attached by bind.
// No package dependency.
module rda_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [55:0] accel_x_o,
  input logic [55:0] accel_y_o,
  input logic [55:0] accel_z_o,
  input logic        applied_o,
  input logic        saturated_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out word dropped while stalled");

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !applied_o |->
      accel_x_o == '0 && accel_y_o == '0 && accel_z_o == '0 && !saturated_o)
    else $error("skipped particle with nonzero result");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("out valid during reset");

endmodule

bind radiation_drag_accel_top rda_checker u_rda_checker (.*);
